// ----- sv/grb_pkg.sv -----
package grb_pkg;

	typedef logic [31:0] word_t;

	localparam int FSEL_WORDS = 4;
	localparam int PINS_PER_FSEL = 10;
	localparam int PINS_PER_PULL = 16;

	localparam logic [5:0] ADDR_SET = 6'd7;
	localparam logic [5:0] ADDR_CLR = 6'd10;
	localparam logic [5:0] ADDR_LEV = 6'd13;
	localparam logic [5:0] ADDR_PULL = 6'd57;

	localparam logic OP_READ = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [2:0] FSEL_OUTPUT = 3'd1;
	localparam logic [1:0] PULL_UP_CODE = 2'd1;
	localparam logic [1:0] PULL_DOWN_CODE = 2'd2;

	// one bus access as held in the input register
	typedef struct packed {
		logic       op;
		logic [5:0] word_addr;
		word_t      write_data;
		word_t      pad_levels;
	} grb_access_t;

	// read data and pin controls after the access
	typedef struct packed {
		word_t read_data;
		word_t drive_enable;
		word_t drive_value;
		word_t pull_up;
		word_t pull_down;
	} grb_result_t;

endpackage

// ----- sv/grb_regfile.sv -----
module grb_regfile #(
	parameter int PIN_COUNT = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                upd,
	input  grb_pkg::grb_access_t acc,
	output grb_pkg::grb_result_t res
);
	import grb_pkg::*;

	logic [2:0]           fsel_q [PIN_COUNT];
	logic [1:0]           pull_q [PIN_COUNT];
	logic [PIN_COUNT-1:0] latch_q;

	logic [2:0]           fsel_d [PIN_COUNT];
	logic [1:0]           pull_d [PIN_COUNT];
	logic [PIN_COUNT-1:0] latch_d;
	logic                 wr;

	assign wr = (acc.op == OP_WRITE);

	always_comb begin
		latch_d = latch_q;
		if (wr && acc.word_addr == ADDR_SET)
			latch_d = latch_q | acc.write_data[PIN_COUNT-1:0];
		else if (wr && acc.word_addr == ADDR_CLR)
			latch_d = latch_q & ~acc.write_data[PIN_COUNT-1:0];
		for (int p = 0; p < PIN_COUNT; p++) begin
			fsel_d[p] = fsel_q[p];
			pull_d[p] = pull_q[p];
			if (wr && acc.word_addr == 6'(p / PINS_PER_FSEL))
				fsel_d[p] = acc.write_data[3*(p % PINS_PER_FSEL) +: 3];
			if (wr && acc.word_addr == ADDR_PULL + 6'(p / PINS_PER_PULL))
				pull_d[p] = acc.write_data[2*(p % PINS_PER_PULL) +: 2];
		end
	end

	// read data from the state before the access, controls from the state after
	always_comb begin
		res = '0;
		for (int p = 0; p < PIN_COUNT; p++) begin
			if (acc.word_addr == 6'(p / PINS_PER_FSEL))
				res.read_data[3*(p % PINS_PER_FSEL) +: 3] = fsel_q[p];
			if (acc.word_addr == ADDR_PULL + 6'(p / PINS_PER_PULL))
				res.read_data[2*(p % PINS_PER_PULL) +: 2] = pull_q[p];
			if (acc.word_addr == ADDR_LEV)
				res.read_data[p] = acc.pad_levels[p];
			res.drive_enable[p] = (fsel_d[p] == FSEL_OUTPUT);
			res.pull_up[p] = (pull_d[p] == PULL_UP_CODE);
			res.pull_down[p] = (pull_d[p] == PULL_DOWN_CODE);
		end
		if (wr)
			res.read_data = '0;
		res.drive_value[PIN_COUNT-1:0] = latch_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q <= '0;
			for (int p = 0; p < PIN_COUNT; p++) begin
				fsel_q[p] <= '0;
				pull_q[p] <= '0;
			end
		end else if (upd) begin
			latch_q <= latch_d;
			for (int p = 0; p < PIN_COUNT; p++) begin
				fsel_q[p] <= fsel_d[p];
				pull_q[p] <= pull_d[p];
			end
		end
	end

endmodule

// ----- sv/gpio_register_block.sv -----
// channel | handshake            | payload
// in      | in_valid / in_stall  | op, word_addr, write_data, pad_levels
// out     | out_valid / out_stall| read_data, drive_enable, drive_value, pull_up, pull_down
//
// an access passes through the input register and then the result register,
// one access per cycle sustained while out_stall is low; the access is applied
// to the register state as it moves from the input register to the result register
// reset puts every pin in input mode with no pull and clears the latch
// the input stalls only when both registers are full and the result is stalled;
// an empty input register takes a transfer even while the result is stalled
module gpio_register_block #(
	parameter int PIN_COUNT = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [5:0]  word_addr,
	input  logic [31:0] write_data,
	input  logic [31:0] pad_levels,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_data,
	output logic [31:0] drive_enable,
	output logic [31:0] drive_value,
	output logic [31:0] pull_up,
	output logic [31:0] pull_down
);
	import grb_pkg::*;

	grb_access_t acc_s1;
	logic        valid_s1;
	grb_result_t res;
	grb_result_t res_s2;
	logic        valid_s2;
	logic        advance;

	assign advance = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall)
				valid_s1 <= in_valid;
			if (advance)
				valid_s2 <= 1'b1;
			else if (!out_stall)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			acc_s1 <= '{op: op, word_addr: word_addr, write_data: write_data,
				pad_levels: pad_levels};
		if (advance)
			res_s2 <= res;
	end

	grb_regfile #(
		.PIN_COUNT(PIN_COUNT)
	) u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (advance),
		.acc    (acc_s1),
		.res    (res)
	);

	assign out_valid = valid_s2;
	assign read_data = res_s2.read_data;
	assign drive_enable = res_s2.drive_enable;
	assign drive_value = res_s2.drive_value;
	assign pull_up = res_s2.pull_up;
	assign pull_down = res_s2.pull_down;

	a_no_both_pulls: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pull_up & pull_down) == '0)
		else $error("pull up and pull down both set");

	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("advanced access did not reach the result register");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled without a blocked result");

	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && out_stall) |=> $stable(res_s2))
		else $error("stalled result changed");

endmodule

// ----- bench/grb_result_checker.sv -----
module grb_result_checker #(
	parameter int PIN_COUNT = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        op,
	input  logic [5:0]  word_addr,
	input  logic [31:0] write_data,
	input  logic [31:0] pad_levels,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] read_data,
	input  logic [31:0] drive_enable,
	input  logic [31:0] drive_value,
	input  logic [31:0] pull_up,
	input  logic [31:0] pull_down,
	output int          error_count,
	output int          pending
);
	import grb_pkg::*;

	logic [2:0] pin_function [32];
	logic [1:0] pin_pull [32];
	word_t out_latch;
	grb_result_t expected_results [$];
	int mismatch_total;

	function automatic word_t pin_mask();
		word_t m;
		m = '0;
		for (int p = 0; p < PIN_COUNT; p++)
			m[p] = 1'b1;
		return m;
	endfunction

	// applies one access to the register copy and returns what the block should report
	function automatic grb_result_t apply_access(grb_access_t acc);
		grb_result_t res;
		int base;
		res = '0;
		if (acc.word_addr < FSEL_WORDS) begin
			base = int'(acc.word_addr) * PINS_PER_FSEL;
			for (int k = 0; k < PINS_PER_FSEL; k++) begin
				if (base + k < PIN_COUNT) begin
					if (acc.op == OP_WRITE)
						pin_function[base + k] = acc.write_data[3 * k +: 3];
					else
						res.read_data[3 * k +: 3] = pin_function[base + k];
				end
			end
		end else if (acc.word_addr == ADDR_PULL || acc.word_addr == ADDR_PULL + 6'd1) begin
			base = (int'(acc.word_addr) - int'(ADDR_PULL)) * PINS_PER_PULL;
			for (int k = 0; k < PINS_PER_PULL; k++) begin
				if (base + k < PIN_COUNT) begin
					if (acc.op == OP_WRITE)
						pin_pull[base + k] = acc.write_data[2 * k +: 2];
					else
						res.read_data[2 * k +: 2] = pin_pull[base + k];
				end
			end
		end else if (acc.op == OP_WRITE && acc.word_addr == ADDR_SET) begin
			out_latch = out_latch | (acc.write_data & pin_mask());
		end else if (acc.op == OP_WRITE && acc.word_addr == ADDR_CLR) begin
			out_latch = out_latch & ~(acc.write_data & pin_mask());
		end else if (acc.op == OP_READ && acc.word_addr == ADDR_LEV) begin
			res.read_data = acc.pad_levels & pin_mask();
		end
		// pin controls as they stand after the access
		for (int p = 0; p < PIN_COUNT; p++) begin
			res.drive_enable[p] = (pin_function[p] == FSEL_OUTPUT);
			res.pull_up[p] = (pin_pull[p] == PULL_UP_CODE);
			res.pull_down[p] = (pin_pull[p] == PULL_DOWN_CODE);
		end
		res.drive_value = out_latch & pin_mask();
		return res;
	endfunction

	task automatic check_field(string field, word_t want, word_t got);
		if (want !== got) begin
			mismatch_total++;
			if (mismatch_total <= 10)
				$display("%0t %s mismatch: expected %h, got %h", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		grb_access_t acc;
		grb_result_t want;
		if (!arst_n) begin
			for (int p = 0; p < 32; p++) begin
				pin_function[p] = '0;
				pin_pull[p] = '0;
			end
			out_latch = '0;
			expected_results.delete();
			mismatch_total = 0;
			error_count <= 0;
			pending <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				acc.op = op;
				acc.word_addr = word_addr;
				acc.write_data = write_data;
				acc.pad_levels = pad_levels;
				expected_results.insert(expected_results.size(), apply_access(acc));
			end
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					mismatch_total++;
					if (mismatch_total <= 10)
						$display("%0t result transfer with no access pending", $time);
				end else begin
					want = expected_results.pop_front();
					check_field("read_data", want.read_data, read_data);
					check_field("drive_enable", want.drive_enable, drive_enable);
					check_field("drive_value", want.drive_value, drive_value);
					check_field("pull_up", want.pull_up, pull_up);
					check_field("pull_down", want.pull_down, pull_down);
				end
			end
			error_count <= mismatch_total;
			pending <= expected_results.size();
		end
	end

endmodule

// ----- bench/tb_gpio_register_block.sv -----
module tb_gpio_register_block;
	import grb_pkg::*;

	localparam int PIN_COUNT = 32;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 60;
	localparam logic [5:0] ADDR_UNMAPPED_LAST = 6'd63;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        op;
	logic [5:0]  word_addr;
	logic [31:0] write_data;
	logic [31:0] pad_levels;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] read_data;
	logic [31:0] drive_enable;
	logic [31:0] drive_value;
	logic [31:0] pull_up;
	logic [31:0] pull_down;

	int error_count;
	int pending;
	int cycle_count = 0;
	bit sender_pacing;
	bit receiver_pacing;
	bit hold_req;

	gpio_register_block #(.PIN_COUNT(PIN_COUNT)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.word_addr(word_addr),
		.write_data(write_data),
		.pad_levels(pad_levels),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_data(read_data),
		.drive_enable(drive_enable),
		.drive_value(drive_value),
		.pull_up(pull_up),
		.pull_down(pull_down)
	);

	grb_result_checker #(.PIN_COUNT(PIN_COUNT)) result_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.word_addr(word_addr),
		.write_data(write_data),
		.pad_levels(pad_levels),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_data(read_data),
		.drive_enable(drive_enable),
		.drive_value(drive_value),
		.pull_up(pull_up),
		.pull_down(pull_down),
		.error_count(error_count),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_gpio_register_block: FAIL");
			$finish;
		end
	end

	// offers one access and returns once it transfers, after a random pause with in_valid low when sender pacing is on
	task automatic send_access(logic acc_op, logic [5:0] addr, word_t data, word_t pads);
		in_valid <= 1'b1;
		op <= acc_op;
		word_addr <= addr;
		write_data <= data;
		pad_levels <= pads;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (sender_pacing && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	task automatic send_random(int count);
		logic [5:0] addr;
		word_t data;
		for (int i = 0; i < count; i++) begin
			data = $urandom;
			case ($urandom_range(0, 9))
				0, 1, 2: addr = 6'($urandom_range(0, FSEL_WORDS - 1));
				3: addr = ADDR_SET;
				4: addr = ADDR_CLR;
				5: addr = ADDR_LEV;
				6, 7: addr = ADDR_PULL + 6'($urandom_range(0, 1));
				default: addr = 6'($urandom_range(0, 63));
			endcase
			// lean on output and pull codes so the pin controls actually toggle
			if ($urandom_range(0, 1)) begin
				if (addr < FSEL_WORDS) begin
					for (int k = 0; k < PINS_PER_FSEL; k++)
						data[3 * k +: 3] = $urandom_range(0, 1) ? FSEL_OUTPUT : 3'd0;
				end else if (addr == ADDR_PULL || addr == ADDR_PULL + 6'd1) begin
					for (int k = 0; k < PINS_PER_PULL; k++)
						data[2 * k +: 2] = $urandom_range(0, 1) ? PULL_UP_CODE : PULL_DOWN_CODE;
				end
			end
			send_access($urandom_range(0, 1) ? OP_WRITE : OP_READ, addr, data, $urandom);
		end
	endtask

	initial begin : receiver_pace
		int span;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (receiver_pacing && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				span = $urandom_range(1, 10);
				repeat (span) @(posedge clk);
				out_stall <= 1'b0;
			end else if (receiver_pacing && $urandom_range(0, 39) == 0) begin
				// stretch with the receiver always ready
				span = $urandom_range(20, 60);
				repeat (span) @(posedge clk);
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		op <= OP_READ;
		word_addr <= '0;
		write_data <= '0;
		pad_levels <= '0;
		sender_pacing = 1'b1;
		receiver_pacing = 1'b1;
		hold_req = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset contents of the function select words
		for (int w = 0; w < FSEL_WORDS; w++)
			send_access(OP_READ, 6'(w), '0, '0);
		// code 7 on every pin of word 0, unused top bits written too
		send_access(OP_WRITE, 6'(0), 32'hffff_ffff, '0);
		send_access(OP_READ, 6'(0), '0, '0);
		// every pin to output, including the bits above the last pin in the top word
		for (int w = 0; w < FSEL_WORDS; w++)
			send_access(OP_WRITE, 6'(w), 32'hc924_9249, '0);
		send_access(OP_READ, 6'(FSEL_WORDS - 1), '0, '0);
		// set and clear words read back zero, then the level word is read and written
		send_access(OP_WRITE, ADDR_SET, 32'hffff_ffff, '0);
		send_access(OP_READ, ADDR_SET, '0, 32'hffff_ffff);
		send_access(OP_WRITE, ADDR_CLR, 32'ha5a5_a5a5, '0);
		send_access(OP_READ, ADDR_CLR, '0, 32'hffff_ffff);
		send_access(OP_READ, ADDR_LEV, '0, 32'hffff_ffff);
		send_access(OP_READ, ADDR_LEV, 32'hffff_ffff, '0);
		send_access(OP_WRITE, ADDR_LEV, 32'hffff_ffff, 32'h1234_5678);
		// pull code 3 on the low pull word, then the high word all up and the low word all down
		send_access(OP_WRITE, ADDR_PULL, 32'hffff_ffff, '0);
		send_access(OP_READ, ADDR_PULL, '0, '0);
		send_access(OP_WRITE, ADDR_PULL + 6'd1, 32'h5555_5555, '0);
		send_access(OP_WRITE, ADDR_PULL, 32'haaaa_aaaa, '0);
		send_access(OP_READ, ADDR_PULL + 6'd1, '0, '0);
		// unmapped words
		send_access(OP_WRITE, ADDR_UNMAPPED_LAST, 32'hffff_ffff, 32'hffff_ffff);
		send_access(OP_READ, ADDR_UNMAPPED_LAST, 32'hffff_ffff, 32'hffff_ffff);
		send_access(OP_READ, 6'(FSEL_WORDS), '0, 32'hffff_ffff);

		send_random(200);

		// receiver holds off while transfers keep coming until the input stalls
		in_valid <= 1'b0;
		sender_pacing = 1'b0;
		hold_req = 1'b1;
		wait (hold_req == 1'b0);
		send_random(60);

		sender_pacing = 1'b1;
		send_random(170);

		sender_pacing = 1'b0;
		receiver_pacing = 1'b0;
		send_random(100);
		in_valid <= 1'b0;

		do
			@(posedge clk);
		while (pending != 0);
		repeat (4) @(posedge clk);
		if (error_count == 0 && pending == 0)
			$display("tb_gpio_register_block: PASS");
		else
			$display("tb_gpio_register_block: FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/grb_pkg.sv
sv/grb_regfile.sv
sv/gpio_register_block.sv
bench/grb_result_checker.sv
bench/tb_gpio_register_block.sv
